FILE: src/swsdac_pkg.sv
// Shared types and constants for the square-wave staircase DAC sequencer.
package swsdac_pkg;

    // Command codes carried on the input channel's tuser.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;
    localparam logic [1:0] CMD_SPACE = 2'd3;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_START_LEVEL = 3'd0;
    localparam logic [2:0] REG_SPAN        = 3'd1;
    localparam logic [2:0] REG_PULSE_AMP   = 3'd2;
    localparam logic [2:0] REG_STEP        = 3'd3;
    localparam logic [2:0] REG_SENSOR_MODE = 3'd4;
    localparam logic [2:0] REG_SCALE       = 3'd5;

    // Reset value of the Q8.8 millivolt-to-code factor (unity).
    localparam logic [15:0] SCALE_RESET = 16'd256;

    // Saturation limit of the swept-channel accumulators.
    localparam logic [16:0] ACC_MAX = 17'h1FFFF;

    // Result item as packed on the output tdata, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic [10:0]        sample_index;
        logic [7:0]         mark_space_diff;
        logic               scan_stopped;
        logic               reached_last;
        logic signed [17:0] staircase_level_mv;
        logic               dac_b_write;
        logic               dac_a_write;
        logic [15:0]        dac_b_code;
        logic [15:0]        dac_a_code;
    } result_t;

endpackage

FILE: src/square_wave_staircase_dac_sequencer_unit.sv
// Square-wave staircase sequencer driving two DAC channel codes.
// A transferred item is held in the input register; the result is computed from it
// and loads the result register when that register is free or drains.
// Throughput: one item per cycle; only a stalled result register holds up the input.
// Reset (aresetn low, synchronous) clears the channels, the scan state and the
// registers to their defaults; the scale register returns to unity (256).
module square_wave_staircase_dac_sequencer_unit
    import swsdac_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] adc_sample
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] dac_a_code, [31:16] dac_b_code,
                                   // [32] dac_a_write, [33] dac_b_write,
                                   // [51:34] staircase_level_mv, [52] reached_last,
                                   // [53] scan_stopped, [61:54] mark_space_diff,
                                   // [72:62] sample_index, [79:73] zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CntW = $clog2(SAMPLE_DEPTH + 1);
    localparam int IdxW = (CntW > 11) ? CntW : 11;

    // Configuration registers
    logic [15:0] start_reg;
    logic [14:0] span_reg;
    logic [14:0] pulse_reg;
    logic [14:0] step_reg;
    logic        mode_reg;
    logic [15:0] scale_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    // Pipeline registers
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_adc_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;
    logic        adv;

    // Scan state
    logic signed [17:0] level_reg, level_next;
    logic               mark_phase_reg, mark_phase_next;
    logic               running_reg, running_next;
    logic               last_reg, last_next;
    logic [16:0]        mark_acc_reg, mark_acc_next;
    logic [16:0]        space_acc_reg, space_acc_next;
    logic [15:0]        code_a_reg, code_a_next;
    logic [15:0]        code_b_reg, code_b_next;
    logic [7:0]         held_reg, held_next;
    logic [CntW-1:0]    count_reg, count_next;

    // Datapath intermediates
    logic signed [17:0] start_ext;
    logic signed [17:0] last_lvl;
    logic signed [17:0] lvl_load;
    logic signed [17:0] lvl_dec;
    logic signed [18:0] lvl_pulse;
    logic [17:0]        mark_sum;
    logic [17:0]        space_sum;
    logic [16:0]        mark_sat;
    logic [16:0]        space_sat;
    logic signed [18:0] conv_mv;
    logic [33:0]        conv_prod;
    logic [15:0]        conv_code;
    logic               set_fixed;
    logic               set_swept;
    logic               clr_both;
    logic [15:0]        swept_val;
    logic [7:0]         diff;
    logic [IdxW-1:0]    idx_wide;

    // Configuration port: always ready, write on the access cycle.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            span_reg  <= '0;
            pulse_reg <= '0;
            step_reg  <= '0;
            mode_reg  <= 1'b0;
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_START_LEVEL: start_reg <= pwdata[15:0];
                REG_SPAN:        span_reg  <= pwdata[14:0];
                REG_PULSE_AMP:   pulse_reg <= pwdata[14:0];
                REG_STEP:        step_reg  <= pwdata[14:0];
                REG_SENSOR_MODE: mode_reg  <= pwdata[0];
                REG_SCALE:       scale_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_START_LEVEL: prdata = {16'd0, start_reg};
            REG_SPAN:        prdata = {17'd0, span_reg};
            REG_PULSE_AMP:   prdata = {17'd0, pulse_reg};
            REG_STEP:        prdata = {17'd0, step_reg};
            REG_SENSOR_MODE: prdata = {31'd0, mode_reg};
            REG_SCALE:       prdata = {16'd0, scale_reg};
            default:         prdata = '0;
        endcase
    end

    // Handshake: the held item moves on when the result register is free or drains.
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser;
            in_adc_reg <= s_tdata;
        end
        if (adv) begin
            out_reg <= out_next;
        end
    end

    // Level arithmetic shared by the start and tick commands.
    assign start_ext = {{2{start_reg[15]}}, start_reg};
    assign last_lvl  = start_ext - {3'd0, span_reg};
    assign lvl_load  = start_ext + {3'd0, step_reg};
    assign lvl_dec   = level_reg - {3'd0, step_reg};
    assign lvl_pulse = {lvl_dec[17], lvl_dec} + {5'd0, pulse_reg[14:1]};

    // Saturating accumulator updates for the swept channel.
    assign mark_sum  = {1'b0, mark_acc_reg} + {3'd0, step_reg};
    assign space_sum = {1'b0, space_acc_reg} + {3'd0, step_reg};
    assign mark_sat  = mark_sum[17] ? ACC_MAX : mark_sum[16:0];
    assign space_sat = space_sum[17] ? ACC_MAX : space_sum[16:0];

    // Millivolt-to-code conversion: one multiplier, negative clamps to zero, overflow to 0xFFFF.
    assign conv_prod = conv_mv[17:0] * scale_reg;
    assign conv_code = conv_mv[18] ? 16'd0 :
                       ((|conv_prod[33:24]) ? 16'hFFFF : conv_prod[23:8]);

    // Command decode and next scan state.
    always_comb begin
        level_next      = level_reg;
        mark_phase_next = mark_phase_reg;
        running_next    = running_reg;
        last_next       = last_reg;
        mark_acc_next   = mark_acc_reg;
        space_acc_next  = space_acc_reg;
        held_next       = held_reg;
        count_next      = count_reg;
        conv_mv         = {lvl_load[17], lvl_load};
        set_fixed       = 1'b0;
        set_swept       = 1'b0;
        clr_both        = 1'b0;
        swept_val       = conv_code;
        diff            = '0;
        idx_wide        = IdxW'(count_reg);

        case (in_cmd_reg)
            CMD_START: begin
                level_next      = lvl_load;
                mark_phase_next = 1'b1;
                running_next    = 1'b1;
                last_next       = 1'b0;
                mark_acc_next   = '0;
                space_acc_next  = '0;
                count_next      = '0;
                idx_wide        = '0;
                conv_mv         = {lvl_load[17], lvl_load};
                set_fixed       = 1'b1;
                set_swept       = 1'b1;
                swept_val       = '0;
            end
            CMD_TICK: begin
                if (running_reg && mark_phase_reg) begin
                    // Mark half-period: step the staircase down.
                    mark_phase_next = 1'b0;
                    level_next      = lvl_dec;
                    if (lvl_dec <= last_lvl) begin
                        last_next = 1'b1;
                    end
                    if (lvl_dec < last_lvl) begin
                        running_next    = 1'b0;
                        mark_phase_next = 1'b1;
                        clr_both        = 1'b1;
                    end else if (lvl_dec == start_ext) begin
                        // First step: fixed channel gets half the pulse on top.
                        conv_mv       = lvl_pulse;
                        set_fixed     = 1'b1;
                        set_swept     = 1'b1;
                        swept_val     = '0;
                        mark_acc_next = '0;
                    end else begin
                        mark_acc_next = mark_sat;
                        conv_mv       = {2'b00, mark_sat};
                        set_swept     = 1'b1;
                    end
                end else if (running_reg) begin
                    // Space half-period: load or advance the space accumulator.
                    mark_phase_next = 1'b1;
                    if (level_reg == start_ext) begin
                        space_acc_next = {2'b00, pulse_reg};
                        conv_mv        = {4'd0, pulse_reg};
                    end else begin
                        space_acc_next = space_sat;
                        conv_mv        = {2'b00, space_sat};
                    end
                    set_swept = 1'b1;
                end
            end
            CMD_MARK: begin
                held_next = in_adc_reg;
            end
            default: begin
                diff = (in_adc_reg >= held_reg) ? (in_adc_reg - held_reg)
                                                : (held_reg - in_adc_reg);
                if (count_reg < CntW'(SAMPLE_DEPTH)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        endcase
    end

    // Channel routing: mode 1 sweeps channel A, mode 0 sweeps channel B.
    always_comb begin
        code_a_next = code_a_reg;
        code_b_next = code_b_reg;
        if (clr_both) begin
            code_a_next = '0;
            code_b_next = '0;
        end else begin
            if (set_fixed) begin
                if (mode_reg) begin
                    code_b_next = conv_code;
                end else begin
                    code_a_next = conv_code;
                end
            end
            if (set_swept) begin
                if (mode_reg) begin
                    code_a_next = swept_val;
                end else begin
                    code_b_next = swept_val;
                end
            end
        end
    end

    // Result assembly; the last written code always equals the held channel code.
    always_comb begin
        out_next                    = '0;
        out_next.dac_a_code         = code_a_next;
        out_next.dac_b_code         = code_b_next;
        out_next.dac_a_write        = (code_a_next != code_a_reg);
        out_next.dac_b_write        = (code_b_next != code_b_reg);
        out_next.staircase_level_mv = level_next;
        out_next.reached_last       = last_next;
        out_next.scan_stopped       = !running_next;
        out_next.mark_space_diff    = diff;
        out_next.sample_index       = idx_wide[10:0];
    end

    // Scan state registers advance with each processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= '0;
            mark_phase_reg <= 1'b1;
            running_reg    <= 1'b0;
            last_reg       <= 1'b0;
            mark_acc_reg   <= '0;
            space_acc_reg  <= '0;
            code_a_reg     <= '0;
            code_b_reg     <= '0;
            held_reg       <= '0;
            count_reg      <= '0;
        end else if (adv) begin
            level_reg      <= level_next;
            mark_phase_reg <= mark_phase_next;
            running_reg    <= running_next;
            last_reg       <= last_next;
            mark_acc_reg   <= mark_acc_next;
            space_acc_reg  <= space_acc_next;
            code_a_reg     <= code_a_next;
            code_b_reg     <= code_b_next;
            held_reg       <= held_next;
            count_reg      <= count_next;
        end
    end

endmodule
